// ===== hdl/satf_pkg.sv =====
// Package for the sliding average temperature filter.
// Holds the window size, derived widths and the controller/datapath interface types.
// No dependencies.
package satf_pkg;

	// Number of samples held in the averaging window (1 to 256).
	localparam int WINDOW_LENGTH = 16;

	localparam int SAMPLE_W = 16;
	localparam int FAHR_W   = 17;
	localparam int PTR_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);
	localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LENGTH);
	// The divider quotient must also hold the 17-bit mean magnitude.
	localparam int DIV_W    = (SUM_W > FAHR_W) ? SUM_W : FAHR_W;
	localparam int DVS_W    = CNT_W;
	localparam int STEP_W   = $clog2(DIV_W);

	// |mean| * 9 + 2 stays below 2^19.
	localparam int FAHR_NUM_W = 19;
	// Division by five as a multiply by ceil(2^21 / 5) and a shift by 21; the
	// error term stays below one for every numerator under 2^19.
	localparam int FAHR_SHIFT = 21;

	// 32 degrees Fahrenheit in 1/16 degree units.
	localparam logic [FAHR_W-1:0]     FAHR_OFFSET = FAHR_W'(512);
	localparam logic [FAHR_NUM_W-1:0] FAHR_RECIP  = FAHR_NUM_W'(419431);
	localparam logic [FAHR_NUM_W-1:0] FAHR_ROUND  = FAHR_NUM_W'(2);

	typedef struct packed {
		logic capture;   // take the incoming word
		logic rd_old;    // read the slot about to be overwritten
		logic update;    // update sum, count, pointer and write the window
		logic setup_c;   // load the divider for the Celsius mean
		logic setup_f;   // latch the mean and its Fahrenheit quotient
		logic div_step;  // one restoring-division step
		logic out_load;  // load the output registers
	} satf_cmd_t;

	typedef struct packed {
		logic div_last;  // the current division step is the final one
	} satf_sts_t;

endpackage

// ===== hdl/satf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module satf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/satf_ctrl.sv =====
// Controller state machine of the sliding average temperature filter.
// Depends on satf_pkg for the command and status types.
module satf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output satf_pkg::satf_cmd_t cmd,
	input  satf_pkg::satf_sts_t sts
);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b000_0001,
		ST_LOAD    = 7'b000_0010,
		ST_UPDATE  = 7'b000_0100,
		ST_SETUP_C = 7'b000_1000,
		ST_DIV_C   = 7'b001_0000,
		ST_SETUP_F = 7'b010_0000,
		ST_DONE    = 7'b100_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.rd_old = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_SETUP_C;
			end
			ST_SETUP_C: begin
				cmd.setup_c = 1'b1;
				state_d     = ST_DIV_C;
			end
			ST_DIV_C: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SETUP_F;
				end
			end
			ST_SETUP_F: begin
				cmd.setup_f = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted word always moves on to the window read.
	a_accept_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_LOAD))
		else $error("accepted word did not start processing");

	// A finished result with a free output register is presented next cycle.
	a_done_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result was not presented");

	// The output register is loaded only when it is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten");

endmodule

// ===== hdl/satf_datapath.sv =====
// Datapath of the sliding average temperature filter: window RAM, running sum,
// fill count, a bit-serial restoring divider and a reciprocal multiplier by 1/5.
// Depends on satf_pkg and satf_ram.
module satf_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [satf_pkg::SAMPLE_W-1:0] celsius_sample,
	output logic signed [satf_pkg::SAMPLE_W-1:0] celsius_average,
	output logic signed [satf_pkg::FAHR_W-1:0]   fahrenheit_average,
	input  satf_pkg::satf_cmd_t                cmd,
	output satf_pkg::satf_sts_t                sts
);

	localparam int SW = satf_pkg::SUM_W;
	localparam int DW = satf_pkg::DIV_W;
	localparam int VW = satf_pkg::DVS_W;
	localparam int PW = 2 * satf_pkg::FAHR_NUM_W;

	logic signed [satf_pkg::SAMPLE_W-1:0] sample_q;
	logic signed [satf_pkg::SAMPLE_W-1:0] old_sample;
	logic [satf_pkg::PTR_W-1:0]           pos_q;
	logic [satf_pkg::CNT_W-1:0]           fill_q;
	logic signed [SW-1:0]                 total_q;
	logic                                 full;

	// Divider state: quo_q shifts the numerator out and the quotient in.
	logic [DW-1:0]                  quo_q;
	logic [VW-1:0]                  rem_q;
	logic [VW-1:0]                  dvs_q;
	logic [satf_pkg::STEP_W-1:0]    step_q;
	logic                           neg_q;
	logic [VW:0]                    shifted;
	logic                           fits;

	logic signed [SW:0]             tot_ext;
	logic [SW-1:0]                  tot_mag;
	logic [DW-1:0]                  num_c;
	logic [satf_pkg::FAHR_W-1:0]    qmag;
	logic [satf_pkg::FAHR_NUM_W-1:0] num_f;
	logic [PW-1:0]                  prod_f;
	logic [satf_pkg::FAHR_W-1:0]    fq_q;
	logic signed [satf_pkg::SAMPLE_W-1:0] avg_q;
	logic [satf_pkg::FAHR_W-1:0]    fval;

	satf_ram #(
		.WIDTH (satf_pkg::SAMPLE_W),
		.DEPTH (satf_pkg::WINDOW_LENGTH)
	) u_window (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (cmd.rd_old),
		.raddr (pos_q),
		.rdata (old_sample)
	);

	assign full = (fill_q == satf_pkg::CNT_W'(satf_pkg::WINDOW_LENGTH));

	// Rounded magnitude numerator for the Celsius mean.
	assign tot_ext = {total_q[SW-1], total_q};
	assign tot_mag = SW'(total_q[SW-1] ? (-tot_ext) : tot_ext);
	assign num_c   = DW'(tot_mag) + DW'(fill_q >> 1);

	// |avg| * 9 + 2, then the division by five as a reciprocal multiply.
	assign qmag   = quo_q[satf_pkg::FAHR_W-1:0];
	assign num_f  = (satf_pkg::FAHR_NUM_W'(qmag) << 3) + satf_pkg::FAHR_NUM_W'(qmag)
		+ satf_pkg::FAHR_ROUND;
	assign prod_f = PW'(num_f) * PW'(satf_pkg::FAHR_RECIP);

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = (shifted >= {1'b0, dvs_q});
	assign sts.div_last = (step_q == '0);

	assign fval = (neg_q ? (-fq_q) : fq_q) + satf_pkg::FAHR_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (cmd.update) begin
			total_q <= total_q + SW'(sample_q) - (full ? SW'(old_sample) : SW'(0));
			if (!full) begin
				fill_q <= fill_q + satf_pkg::CNT_W'(1);
			end
			if (pos_q == satf_pkg::PTR_W'(satf_pkg::WINDOW_LENGTH - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + satf_pkg::PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= celsius_sample;
		end
		if (cmd.setup_c) begin
			quo_q  <= num_c;
			rem_q  <= '0;
			dvs_q  <= VW'(fill_q);
			neg_q  <= total_q[SW-1];
			step_q <= satf_pkg::STEP_W'(DW - 1);
		end else if (cmd.setup_f) begin
			avg_q  <= neg_q ? (-quo_q[15:0]) : quo_q[15:0];
			fq_q   <= prod_f[satf_pkg::FAHR_SHIFT +: satf_pkg::FAHR_W];
		end else if (cmd.div_step) begin
			rem_q  <= fits ? VW'(shifted - {1'b0, dvs_q}) : shifted[VW-1:0];
			quo_q  <= {quo_q[DW-2:0], fits};
			step_q <= step_q - satf_pkg::STEP_W'(1);
		end
		if (cmd.out_load) begin
			celsius_average    <= avg_q;
			fahrenheit_average <= fval;
		end
	end

	// The fill count never passes the window length.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= satf_pkg::CNT_W'(satf_pkg::WINDOW_LENGTH))
		else $error("fill count overran window");

	// While filling, the write pointer equals the count of samples held.
	a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> (satf_pkg::CNT_W'(pos_q) == fill_q))
		else $error("write pointer out of step with fill count");

	// The partial remainder stays below a nonzero divisor during division.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < dvs_q && dvs_q != '0))
		else $error("divider remainder out of range");

endmodule

// ===== hdl/sliding_average_temperature_filter.sv =====
// Top level of the sliding average temperature filter.
// Depends on satf_pkg, satf_ctrl and satf_datapath (which holds satf_ram).
//
// Each accepted word is one Celsius sample in signed 1/16 degree units. The
// block keeps the last WINDOW_LENGTH samples (16 by default) in a small RAM,
// together with an exact running sum and a fill count that saturates at the
// window length. Every sample yields one result word: the window mean rounded
// to nearest (ties away from zero), which during warm-up is the mean of all
// samples seen since reset, and the same mean in Fahrenheit, computed as
// round(mean * 9 / 5) + 512, again in 1/16 degree units. After acceptance a
// word passes through the window read, the sum update and the divider load;
// the division by the fill count then runs one quotient bit per cycle through
// a restoring divider of DIV_W bits, followed by the Fahrenheit step (a
// reciprocal multiply by 1/5) and the load of the output register. The next
// sample is accepted in the cycle after the result is loaded, so no new
// sample is taken while one is still being processed. The result sits in
// an output register, so the next sample is accepted while a finished
// result still waits to be taken; a second finished result holds in_ready
// low until the first is taken. The window RAM needs no clearing after
// reset, since a slot's old value is used only once the window is full
// and every slot has been written.
module sliding_average_temperature_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [satf_pkg::SAMPLE_W-1:0] celsius_sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [satf_pkg::SAMPLE_W-1:0] celsius_average,
	output logic signed [satf_pkg::FAHR_W-1:0]   fahrenheit_average
);

	satf_pkg::satf_cmd_t cmd;
	satf_pkg::satf_sts_t sts;

	// The controller sequences read, update, the division and the conversion.
	satf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath owns the window, the sum, the divider and the output word.
	satf_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.celsius_sample     (celsius_sample),
		.celsius_average    (celsius_average),
		.fahrenheit_average (fahrenheit_average),
		.cmd                (cmd),
		.sts                (sts)
	);

endmodule

// ===== test/tb_sliding_average_temperature_filter.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sliding_average_temperature_filter.
// Depends on satf_pkg and the filter RTL. It predicts each windowed mean and its
// Fahrenheit conversion and compares every result word against that prediction.
module tb_sliding_average_temperature_filter;

	typedef logic signed [satf_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic signed [satf_pkg::FAHR_W-1:0]   fahr_t;

	// One predicted result word, in the same widths as the output ports.
	typedef struct packed {
		sample_t celsius;
		fahr_t   fahrenheit;
	} mean_word_t;

	// Flavors of random sample streams used in the mixed phase.
	typedef enum int {
		SEG_UNIFORM,
		SEG_DRIFT,
		SEG_HOT_RAIL,
		SEG_COLD_RAIL,
		SEG_NEAR_ZERO
	} stream_kind_t;

	localparam int          IDLE_PERCENT  = 11;
	localparam int          HOLDOFF_LEN   = 300;
	// One serial division plus pipeline overhead, with some slack.
	localparam int          DRAIN_CYCLES  = satf_pkg::DIV_W + 5 + 20;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int          STEADY_ITEMS  = 200;
	localparam int          MIXED_ITEMS   = 1600;
	localparam int          PRESSURE_ITEMS = 24;
	localparam int          REPORT_LIMIT  = 10;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t celsius_sample = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t celsius_average;
	fahr_t   fahrenheit_average;

	sliding_average_temperature_filter uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.celsius_sample     (celsius_sample),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.celsius_average    (celsius_average),
		.fahrenheit_average (fahrenheit_average)
	);

	// 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Shadow copy of the filter state: the last WINDOW_LENGTH samples, the slot
	// that takes the next one, how many are held, and their exact sum.
	sample_t    held_samples [satf_pkg::WINDOW_LENGTH];
	int         next_slot = 0;
	int         held_count = 0;
	longint     running_total = 0;

	// Result words that have been predicted but not yet taken from the block.
	mean_word_t pending_means [$];

	int unsigned cycle_count = 0;
	int          words_sent = 0;
	int          words_checked = 0;
	int          mismatch_count = 0;
	int          tie_count = 0;

	// The sender pauses at random unless told to stream; the receiver does the
	// same on its own flag, which is updated with a nonblocking write so the
	// ready process never races with the test sequence.
	bit          sender_steady = 1'b0;
	bit          receiver_steady = 1'b0;
	logic        holding_output = 1'b0;
	event        start_holdoff;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Rounded division with ties going away from zero; the divisor is positive.
	function automatic longint div_nearest(input longint num, input longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// Advances the shadow window by one sample and returns the result word the
	// block must produce for it. Once the window is full, the sample in the
	// slot being overwritten leaves the sum before the new one enters.
	function automatic mean_word_t predict_window_mean(input sample_t sample);
		longint     mean_c;
		longint     mean_f;
		mean_word_t word;
		if (held_count == satf_pkg::WINDOW_LENGTH)
			running_total -= longint'(held_samples[next_slot]);
		running_total += longint'(sample);
		held_samples[next_slot] = sample;
		next_slot = (next_slot + 1) % satf_pkg::WINDOW_LENGTH;
		if (held_count < satf_pkg::WINDOW_LENGTH)
			held_count++;
		// A halfway quotient only happens when twice the sum is an odd
		// multiple of the count; track how often the stimulus lands there.
		if ((running_total % held_count) != 0 && (2 * running_total) % held_count == 0)
			tie_count++;
		mean_c = div_nearest(running_total, held_count);
		mean_f = div_nearest(mean_c * 9, 5) + 512;
		word.celsius    = satf_pkg::SAMPLE_W'(mean_c);
		word.fahrenheit = satf_pkg::FAHR_W'(mean_f);
		return word;
	endfunction

	// Offers one sample and returns right after the edge that accepted it.
	// The task never drops in_valid after acceptance itself: the next call
	// either lowers it for an idle gap or replaces the word directly, so the
	// valid line gets a single write per time step.
	task automatic send_sample(input sample_t value);
		if (!sender_steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		celsius_sample <= value;
		do @(posedge clk); while (!in_ready);
		pending_means.push_back(predict_window_mean(value));
		words_sent++;
	endtask

	task automatic set_steady(input bit on);
		sender_steady = on;
		receiver_steady <= on;
	endtask

	// Receiver: ready is redrawn every cycle, except during a long hold-off.
	always @(posedge clk) begin
		if (holding_output)
			out_ready <= 1'b0;
		else
			out_ready <= receiver_steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// The hold-off length is counted here, apart from the sender, so the test
	// can keep offering samples while the output side stays blocked.
	always begin
		@(start_holdoff);
		holding_output <= 1'b1;
		repeat (HOLDOFF_LEN) @(posedge clk);
		holding_output <= 1'b0;
	end

	task automatic note_mismatch(input string what, input mean_word_t want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("MISMATCH at cycle %0d: %s; expected C=%0d F=%0d, got C=%0d F=%0d",
				cycle_count, what, want.celsius, want.fahrenheit,
				celsius_average, fahrenheit_average);
	endtask

	// Result checker: every word taken from the block is compared against the
	// oldest prediction, field by field.
	always @(posedge clk) begin
		mean_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_means.size() == 0) begin
				want = '0;
				note_mismatch("result word with no prediction waiting", want);
			end else begin
				want = pending_means.pop_front();
				words_checked++;
				if (celsius_average !== want.celsius)
					note_mismatch("celsius_average differs", want);
				if (fahrenheit_average !== want.fahrenheit)
					note_mismatch("fahrenheit_average differs", want);
			end
		end
	end

	// Warm-up means with halfway quotients of both signs: 3/2 rounds up to 2,
	// -10/4 rounds down to -3, with -5/3 in between as an ordinary case.
	task automatic test_rounding_ties();
		send_sample(sample_t'(1));
		send_sample(sample_t'(2));
		send_sample(sample_t'(-8));
		send_sample(sample_t'(-5));
	endtask

	// Full-scale samples. The window fills part way through the cold run, so
	// the last few words also exercise eviction of the earliest samples.
	task automatic test_input_extremes();
		repeat (10) send_sample(sample_t'(32767));
		repeat (6) send_sample(sample_t'(-32768));
		send_sample(sample_t'(0));
		send_sample(sample_t'(-1));
	endtask

	// The receiver stops for a long stretch while the sender keeps streaming,
	// so the result register and the datapath fill and in_ready must drop.
	task automatic test_output_stall();
		sender_steady = 1'b1;
		-> start_holdoff;
		repeat (PRESSURE_ITEMS) send_sample(sample_t'($urandom_range(65535)));
		sender_steady = 1'b0;
	endtask

	// Back-to-back traffic with neither side pausing.
	task automatic test_steady_stream();
		set_steady(1'b1);
		repeat (STEADY_ITEMS) send_sample(sample_t'($urandom_range(65535)));
		set_steady(1'b0);
	endtask

	// Runs of different sample flavors: uniform noise, slowly drifting room
	// temperatures, long runs pinned at either rail so the mean reaches the
	// output extremes, and tiny values where halfway quotients are common.
	task automatic test_mixed_random();
		stream_kind_t kind;
		int           run_len;
		int           level;
		int           sent;
		sent = 0;
		while (sent < MIXED_ITEMS) begin
			kind    = stream_kind_t'($urandom_range(SEG_NEAR_ZERO));
			run_len = $urandom_range(48, 16);
			level   = int'($urandom_range(2400)) - 800;
			repeat (run_len) begin
				unique case (kind)
					SEG_UNIFORM: begin
						send_sample(sample_t'($urandom_range(65535)));
					end
					SEG_DRIFT: begin
						level += int'($urandom_range(80)) - 40;
						if (level > 32767)
							level = 32767;
						if (level < -32768)
							level = -32768;
						send_sample(sample_t'(level));
					end
					SEG_HOT_RAIL: begin
						send_sample(sample_t'(32767 - int'($urandom_range(99) < 10)));
					end
					SEG_COLD_RAIL: begin
						send_sample(sample_t'(-32768 + int'($urandom_range(99) < 10)));
					end
					default: begin
						send_sample(sample_t'(int'($urandom_range(6)) - 3));
					end
				endcase
			end
			sent += run_len;
		end
	endtask

	// Stop offering, let every predicted word come out, then watch a little
	// longer for stray results.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rounding_ties();
		test_input_extremes();
		test_output_stall();
		test_steady_stream();
		test_mixed_random();
		drain_results();
		$display("Sent %0d samples and checked %0d result words (%0d halfway means).",
			words_sent, words_checked, tie_count);
		$display("Covered warm-up, rail values, window wrap, a %0d-cycle output stall.",
			HOLDOFF_LEN);
		if (mismatch_count == 0 && pending_means.size() == 0) begin
			$display("tb_sliding_average_temperature_filter passed");
		end else begin
			$display("%0d mismatches, %0d words still expected", mismatch_count,
				pending_means.size());
			$display("tb_sliding_average_temperature_filter failed");
		end
		$finish;
	end

	// Watchdog on the cycle counter.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("Timeout after %0d cycles with %0d words still expected", cycle_count,
			pending_means.size());
		$display("tb_sliding_average_temperature_filter failed");
		$finish;
	end

endmodule
